// File: rtl/core/bba_pkg.sv
// Shared constants, codes and interface structs for the bitmap block allocator.
// No dependencies; every other file of the block imports this package.
package bba_pkg;

  localparam int MAX_UNITS  = 1024;
  localparam int WORD_BITS  = 32;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int MAP_WORDS  = (MAX_UNITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int IDX_W      = WORD_AW + BIT_W;
  localparam int CNT_W      = $clog2(MAX_UNITS + 1);

  localparam int ADDR_W     = 32;
  localparam int UNIT_W     = 13;
  localparam int RANGE_W    = 11;
  localparam int PROD_W     = CNT_W + UNIT_W;
  localparam int DIV_CW     = $clog2(PROD_W);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int IN_W       = 32;
  localparam int OP_W       = 2;
  localparam int STAT_W     = 3;
  localparam int OUT_USED_W = ADDR_W + STAT_W + CNT_W;
  localparam int OUT_W      = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD    = OUT_W - OUT_USED_W;

  // Reset values of the configuration registers
  localparam logic [ADDR_W-1:0]  POOL_BASE_RST = '0;
  localparam logic [UNIT_W-1:0]  UNIT_BYTES_RST = UNIT_W'(64);
  localparam logic [RANGE_W-1:0] UNITS_RST = RANGE_W'(1024);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_BASE  = 2'd0,
    CFG_UNIT_BYTES = 2'd1,
    CFG_UNITS      = 2'd2,
    CFG_SPARE      = 2'd3
  } cfg_idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_MISALIGNED = 3'd2,
    ST_RANGE      = 3'd3,
    ST_DOUBLE     = 3'd4
  } status_t;

  // Request to the free-map memory
  typedef struct packed {
    logic                 rd_en;
    logic [WORD_AW-1:0]   rd_addr;
    logic                 wr_en;
    logic [WORD_AW-1:0]   wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 clr;
  } map_cmd_t;

  // Divider start and result
  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [UNIT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quot;
    logic [UNIT_W-1:0] rem;
  } div_rsp_t;

endpackage

// File: rtl/core/bba_map_mem.sv
// Free-map memory: one word per 32 units, registered read.
// Per-word valid bits make an unwritten or cleared word read as all free.
// Depends on bba_pkg.
module bba_map_mem
  import bba_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  map_cmd_t             cmd,
  output logic [WORD_BITS-1:0] rd_data
);

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] vld_r;
  logic [WORD_BITS-1:0] q_r;
  logic                 qv_r;

  // Write and read the array
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      q_r <= mem[cmd.rd_addr];
    end
  end

  // Track which words hold written data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      qv_r  <= 1'b0;
    end else begin
      if (cmd.clr) begin
        vld_r <= '0;
      end else if (cmd.wr_en) begin
        vld_r[cmd.wr_addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        qv_r <= vld_r[cmd.rd_addr];
      end
    end
  end

  // An invalid word reads as all units free
  assign rd_data = qv_r ? q_r : '1;

endmodule

// File: rtl/core/bba_div.sv
// Restoring divider, one quotient bit per cycle, for offset / unit size.
// Depends on bba_pkg.
module bba_div
  import bba_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [UNIT_W-1:0] rem_r;
  logic [PROD_W-1:0] quo_r;
  logic [UNIT_W-1:0] dvs_r;
  logic [UNIT_W:0]   shifted;
  logic              take;
  logic [UNIT_W:0]   diff;

  // Shift in the next dividend bit and try a subtract
  assign shifted = {rem_r, quo_r[PROD_W-1]};
  assign take    = (shifted >= {1'b0, dvs_r});
  assign diff    = shifted - {1'b0, dvs_r};

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CW'(1);
        if (cnt_r == DIV_CW'(PROD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= take ? diff[UNIT_W-1:0] : shifted[UNIT_W-1:0];
      quo_r <= {quo_r[PROD_W-2:0], take};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

// File: rtl/core/bitmap_block_allocator_unit.sv
// Bitmap block allocator top level: config registers, sequencer, result register.
// Items are handled one at a time: an allocate scans from 1 to 32 map words, a free runs the
//   divider unless out of range, and init clears the map. The next input transfer is taken
//   once the result is queued in the result register, which may wait on out_tready.
// Synchronous active-low reset: map reads as all free, count zero, config at defaults.
module bitmap_block_allocator_unit
  import bba_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,   // [31:0] address
  input  logic [OP_W-1:0]       in_tuser,   // [1:0] operation
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata   // [31:0] block_address, [34:32] status,
                                            // [45:35] used_units, rest zero
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_CHK,
    S_A_MUL,
    S_A_ADD,
    S_F_CMP,
    S_F_DIV,
    S_F_CHK,
    S_RESP
  } state_t;

  // Config registers
  logic [ADDR_W-1:0]  pool_base_r;
  logic [UNIT_W-1:0]  unit_bytes_r;
  logic [RANGE_W-1:0] units_r;

  // Sequencer state
  state_t             state_r, state_nxt;
  op_t                op_r, op_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [WORD_AW-1:0] word_r, word_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]  res_block_r, res_block_nxt;
  status_t            res_stat_r, res_stat_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic [OUT_W-1:0]   out_data_r, out_data_nxt;
  logic [PROD_W-1:0]  prod_r;

  // Effective config and derived values
  logic [UNIT_W-1:0]    unit_eff;
  logic [CNT_W-1:0]     n_eff;
  logic [CNT_W-1:0]     n_m1;
  logic [WORD_AW-1:0]   last_word;
  logic [BIT_W-1:0]     last_bit;
  logic [CNT_W-1:0]     mul_a;
  logic [ADDR_W-1:0]    offset;
  logic [WORD_BITS-1:0] rd_data;
  logic [WORD_BITS-1:0] word_mask;
  logic [WORD_BITS-1:0] avail;
  logic [BIT_W-1:0]     low_bit;
  logic                 in_xfer;

  map_cmd_t map_cmd;
  div_req_t div_req;
  div_rsp_t div_rsp;

  bba_map_mem u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (map_cmd),
    .rd_data (rd_data)
  );

  bba_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r  <= POOL_BASE_RST;
      unit_bytes_r <= UNIT_BYTES_RST;
      units_r      <= UNITS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_POOL_BASE:  pool_base_r  <= cfg_wdata[ADDR_W-1:0];
        CFG_UNIT_BYTES: unit_bytes_r <= cfg_wdata[UNIT_W-1:0];
        CFG_UNITS:      units_r      <= cfg_wdata[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp unit size and unit count
  always_comb begin
    unit_eff = (unit_bytes_r == '0) ? UNIT_W'(1) : unit_bytes_r;
    if (units_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (CNT_W'(units_r) > CNT_W'(MAX_UNITS)) begin
      n_eff = CNT_W'(MAX_UNITS);
    end else begin
      n_eff = CNT_W'(units_r);
    end
  end

  assign n_m1      = n_eff - CNT_W'(1);
  assign last_word = n_m1[IDX_W-1:BIT_W];
  assign last_bit  = n_m1[BIT_W-1:0];
  assign offset    = addr_r - pool_base_r;

  // Shared multiplier: unit count for the free range check, index for allocate
  assign mul_a = (state_r == S_IDLE) ? n_eff : CNT_W'(idx_r);

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(unit_eff);
  end

  // Units of the scanned word that lie inside the pool
  always_comb begin
    if (word_r == last_word) begin
      word_mask = {WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - last_bit);
    end else begin
      word_mask = '1;
    end
    avail = rd_data & word_mask;
  end

  // Lowest free unit of the word
  always_comb begin
    low_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (avail[b]) begin
        low_bit = BIT_W'(b);
      end
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    addr_nxt      = addr_r;
    word_nxt      = word_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    res_block_nxt = res_block_r;
    res_stat_nxt  = res_stat_r;
    out_vld_nxt   = out_vld_r;
    out_data_nxt  = out_data_r;
    map_cmd       = '0;
    div_req       = '0;
    div_req.dividend = offset[PROD_W-1:0];
    div_req.divisor  = unit_eff;

    // Drop the result once it is taken
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt        = op_t'(in_tuser);
          addr_nxt      = in_tdata[ADDR_W-1:0];
          res_block_nxt = '0;
          res_stat_nxt  = ST_OK;
          word_nxt      = '0;
          unique case (op_t'(in_tuser))
            OP_ALLOC: begin
              map_cmd.rd_en   = 1'b1;
              map_cmd.rd_addr = '0;
              state_nxt       = S_A_CHK;
            end
            OP_FREE: begin
              state_nxt = S_F_CMP;
            end
            OP_INIT: begin
              map_cmd.clr = 1'b1;
              cnt_nxt     = '0;
              state_nxt   = S_RESP;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      // Scan one map word per cycle, reading the next one meanwhile
      S_A_CHK: begin
        if (avail != '0) begin
          idx_nxt         = {word_r, low_bit};
          map_cmd.wr_en   = 1'b1;
          map_cmd.wr_addr = word_r;
          map_cmd.wr_data = rd_data & ~(WORD_BITS'(1) << low_bit);
          cnt_nxt         = cnt_r + CNT_W'(1);
          state_nxt       = S_A_MUL;
        end else if (word_r == last_word) begin
          res_stat_nxt = ST_FULL;
          state_nxt    = S_RESP;
        end else begin
          word_nxt        = word_r + WORD_AW'(1);
          map_cmd.rd_en   = 1'b1;
          map_cmd.rd_addr = word_r + WORD_AW'(1);
        end
      end

      S_A_MUL: begin
        state_nxt = S_A_ADD;
      end

      S_A_ADD: begin
        res_block_nxt = pool_base_r + ADDR_W'(prod_r);
        state_nxt     = S_RESP;
      end

      // Range check against pool span, then divide
      S_F_CMP: begin
        if (offset >= ADDR_W'(prod_r)) begin
          res_stat_nxt = ST_RANGE;
          state_nxt    = S_RESP;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = S_F_DIV;
        end
      end

      S_F_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.rem != '0) begin
            res_stat_nxt = ST_MISALIGNED;
            state_nxt    = S_RESP;
          end else begin
            idx_nxt         = div_rsp.quot[IDX_W-1:0];
            map_cmd.rd_en   = 1'b1;
            map_cmd.rd_addr = div_rsp.quot[IDX_W-1:BIT_W];
            state_nxt       = S_F_CHK;
          end
        end
      end

      // Release the unit unless already free
      S_F_CHK: begin
        if (rd_data[idx_r[BIT_W-1:0]]) begin
          res_stat_nxt = ST_DOUBLE;
        end else begin
          map_cmd.wr_en   = 1'b1;
          map_cmd.wr_addr = idx_r[IDX_W-1:BIT_W];
          map_cmd.wr_data = rd_data | (WORD_BITS'(1) << idx_r[BIT_W-1:0]);
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
        end
        state_nxt = S_RESP;
      end

      // Hand the result to the output register when it is free
      S_RESP: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = {{OUT_PAD{1'b0}}, cnt_r, res_stat_r, res_block_r};
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
      op_r      <= OP_NONE;
      word_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
      op_r      <= op_nxt;
      word_r    <= word_nxt;
    end
    addr_r      <= addr_nxt;
    idx_r       <= idx_nxt;
    res_block_r <= res_block_nxt;
    res_stat_r  <= res_stat_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_UNITS))
    else $error("used count above capacity");

  a_init_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (op_t'(in_tuser) == OP_INIT)) |=> (cnt_r == '0))
    else $error("init did not clear used count");

  a_map_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(map_cmd.wr_en && map_cmd.clr))
    else $error("map write during clear");

  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_F_DIV))
    else $error("divider finished outside free sequence");

  a_alloc_op: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_A_CHK) |-> (op_r == OP_ALLOC))
    else $error("scan running for a non-allocate item");
`endif

endmodule

// File: test/bba_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the bitmap block allocator: tracks config writes, predicts each result
// from its own copy of the free map and compares accepted results. Depends on bba_pkg.
module bba_checker
  import bba_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,   // [31:0] address
  input  logic [OP_W-1:0]       in_tuser,   // [1:0] operation
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_W-1:0]      out_tdata,  // [31:0] block_address, [34:32] status,
                                            // [45:35] used_units, rest zero
  output int                    errors,
  output int                    pending
);

  typedef struct {
    logic [ADDR_W-1:0] block;
    status_t           status;
    logic [CNT_W-1:0]  used;
  } alloc_result_t;

  // Shadow configuration and allocator state
  logic [ADDR_W-1:0]    pool_base;
  logic [UNIT_W-1:0]    unit_bytes;
  logic [RANGE_W-1:0]   unit_count;
  logic [WORD_BITS-1:0] free_words [MAP_WORDS];
  logic [CNT_W-1:0]     units_used;

  alloc_result_t awaited_results [$];
  alloc_result_t want;

  initial errors = 0;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
    errors++;
  endtask

  // Apply one request to the shadow state and return the result it should produce
  function automatic alloc_result_t apply_request(op_t op, logic [ADDR_W-1:0] addr);
    alloc_result_t    r;
    int unsigned      n;
    int unsigned      unit;
    int unsigned      idx;
    logic [ADDR_W-1:0] off;
    logic [63:0]      span;
    r.block  = '0;
    r.status = ST_OK;
    n    = (unit_count == 0) ? 1 : unit_count;
    if (n > MAX_UNITS) n = MAX_UNITS;
    unit = (unit_bytes == 0) ? 1 : unit_bytes;
    case (op)
      OP_ALLOC: begin
        // Lowest free unit below the active count wins
        r.status = ST_FULL;
        for (int i = 0; i < n && r.status == ST_FULL; i++) begin
          if (free_words[i / WORD_BITS][i % WORD_BITS]) begin
            free_words[i / WORD_BITS][i % WORD_BITS] = 1'b0;
            units_used = units_used + 1'b1;
            r.block  = pool_base + ADDR_W'(i * unit);
            r.status = ST_OK;
          end
        end
      end
      OP_FREE: begin
        // Offset wraps modulo 2^32 before the range check
        off  = addr - pool_base;
        span = 64'(n) * 64'(unit);
        if ({32'b0, off} >= span) begin
          r.status = ST_RANGE;
        end else if (off % unit != 0) begin
          r.status = ST_MISALIGNED;
        end else begin
          idx = off / unit;
          if (free_words[idx / WORD_BITS][idx % WORD_BITS]) begin
            r.status = ST_DOUBLE;
          end else begin
            free_words[idx / WORD_BITS][idx % WORD_BITS] = 1'b1;
            if (units_used != 0) units_used = units_used - 1'b1;
          end
        end
      end
      OP_INIT: begin
        foreach (free_words[w]) free_words[w] = '1;
        units_used = '0;
      end
      default: ;
    endcase
    r.used = units_used;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      pool_base  = POOL_BASE_RST;
      unit_bytes = UNIT_BYTES_RST;
      unit_count = UNITS_RST;
      foreach (free_words[w]) free_words[w] = '1;
      units_used = '0;
      awaited_results.delete();
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_POOL_BASE:  pool_base  = cfg_wdata[ADDR_W-1:0];
          CFG_UNIT_BYTES: unit_bytes = cfg_wdata[UNIT_W-1:0];
          CFG_UNITS:      unit_count = cfg_wdata[RANGE_W-1:0];
          default: ;
        endcase
      end

      // Compare each result transfer with the oldest prediction
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result with nothing pending", 64'(out_tdata), 64'(0));
        end else begin
          want = awaited_results.pop_front();
          if (out_tdata[ADDR_W-1:0] !== want.block)
            report_mismatch("block_address", 64'(out_tdata[ADDR_W-1:0]), 64'(want.block));
          if (out_tdata[ADDR_W +: STAT_W] !== want.status)
            report_mismatch("status", 64'(out_tdata[ADDR_W +: STAT_W]), 64'(want.status));
          if (out_tdata[ADDR_W + STAT_W +: CNT_W] !== want.used)
            report_mismatch("used_units", 64'(out_tdata[ADDR_W + STAT_W +: CNT_W]),
                            64'(want.used));
          if (out_tdata[OUT_W-1 -: OUT_PAD] !== '0)
            report_mismatch("padding", 64'(out_tdata[OUT_W-1 -: OUT_PAD]), 64'(0));
        end
      end

      // Predict on each request transfer
      if (in_tvalid && in_tready)
        awaited_results.push_back(apply_request(op_t'(in_tuser), in_tdata[ADDR_W-1:0]));
    end
    pending <= awaited_results.size();
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Top of the allocator testbench: clock, reset, request stimulus, result stalls, verdict.
// Depends on bba_pkg, bitmap_block_allocator_unit and bba_checker.
module tb_top;
  import bba_pkg::*;

  localparam int RANDOM_PHASES  = 14;
  localparam int PHASE_ITEMS    = 75;
  localparam int DEEP_PHASES    = 4;
  localparam int WATCHDOG_LIMIT = 5000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata = '0;   // [31:0] address
  logic [OP_W-1:0]       in_tuser = '0;   // [1:0] operation
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;       // [31:0] block_address, [34:32] status,
                                          // [45:35] used_units, rest zero
  int errors;
  int pending;

  // Receiver stall control
  logic [1:0]  stall_mode = 2'd0;
  logic [31:0] stall_pat = 32'hFFFF_FFFF;
  logic [4:0]  stall_pos = '0;
  int          quiet_cycles = 0;

  // Stimulus-side view of the effective pool shape, used to aim free addresses
  logic [ADDR_W-1:0] cur_base = '0;
  int unsigned       cur_unit = 64;
  int unsigned       cur_n = MAX_UNITS;

  bitmap_block_allocator_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  bba_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .errors     (errors),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: always ready, or stall on a random bit pattern reloaded each time stall_pos wraps
  always @(posedge clk) begin
    if (stall_mode == 2'd0) out_tready <= 1'b1;
    else out_tready <= stall_pat[stall_pos];
    stall_pos <= stall_pos + 1'b1;
    if (stall_pos == 5'd31)
      stall_pat <= (stall_mode == 2'd2) ? ($urandom() | $urandom()) : $urandom();
  end

  // Watchdog: count cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // Write one register and hold the enable for a single edge
  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_POOL_BASE:  cur_base = value[ADDR_W-1:0];
      CFG_UNIT_BYTES: cur_unit = (value[UNIT_W-1:0] == 0) ? 1 : value[UNIT_W-1:0];
      CFG_UNITS: begin
        cur_n = (value[RANGE_W-1:0] == 0) ? 1 : value[RANGE_W-1:0];
        if (cur_n > MAX_UNITS) cur_n = MAX_UNITS;
      end
      default: ;
    endcase
  endtask

  // Present one request and hold it until the transfer; valid stays high afterwards
  task automatic send_item(op_t op, logic [ADDR_W-1:0] addr);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= addr;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid and wait until every predicted result has been taken
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // One random request, mostly allocations and frees aimed at units of the pool
  task automatic random_item(int alloc_pct, bit init_ok);
    int unsigned       roll;
    int unsigned       k;
    int unsigned       r;
    op_t               op;
    logic [ADDR_W-1:0] a;
    roll = $urandom_range(0, 99);
    a    = $urandom();
    op   = OP_FREE;
    if (roll < alloc_pct) begin
      op = OP_ALLOC;
    end else if (roll < alloc_pct + (100 - alloc_pct) * 2 / 3) begin
      // aligned free, often among the low units where allocations land
      k = ($urandom_range(0, 1) != 0 && cur_n > 64) ? $urandom_range(0, 63)
                                                     : $urandom_range(0, cur_n - 1);
      a = cur_base + ADDR_W'(k * cur_unit);
    end else if (roll < 90) begin
      // off-grid free inside the pool
      r = (cur_unit > 1) ? $urandom_range(1, cur_unit - 1) : 1;
      a = cur_base + ADDR_W'($urandom_range(0, cur_n - 1) * cur_unit + r);
    end else if (roll < 93) begin
      // just past either end of the pool
      if ($urandom_range(0, 1) != 0)
        a = cur_base + ADDR_W'((cur_n + $urandom_range(0, 3)) * cur_unit);
      else
        a = cur_base - ADDR_W'(cur_unit);
    end else if (roll < 96) begin
      op = OP_FREE;
    end else if (roll < 99 || !init_ok) begin
      op = OP_NONE;
    end else begin
      op = OP_INIT;
    end
    send_item(op, a);
  endtask

  initial begin
    bit                    deep;
    bit                    sender_idles;
    int                    burst_left;
    int                    pause_at;
    logic [CFG_DATA_W-1:0] value;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset configuration
    write_reg(CFG_SPARE, $urandom());
    send_item(OP_ALLOC, 32'h0000_0000);
    send_item(OP_ALLOC, 32'hFFFF_FFFF);
    send_item(OP_FREE, 32'h0000_0000);
    send_item(OP_FREE, 32'h0000_0000);      // double free
    send_item(OP_FREE, 32'h0000_0020);      // misaligned
    send_item(OP_FREE, 32'h0001_0000);      // one past the pool
    send_item(OP_FREE, 32'hFFFF_FFFF);      // below base after wrap
    send_item(OP_NONE, 32'hFFFF_FFFF);
    send_item(OP_ALLOC, 32'h0000_0000);
    send_item(OP_INIT, 32'h0000_0000);
    drain_results();

    // Directed: zero unit size and zero count, pool near the top of the address space
    write_reg(CFG_POOL_BASE, 32'hFFFF_FFF0);
    write_reg(CFG_UNIT_BYTES, 32'd0);
    write_reg(CFG_UNITS, 32'd0);
    send_item(OP_ALLOC, 32'h0);
    send_item(OP_ALLOC, 32'h0);             // pool full
    send_item(OP_FREE, 32'hFFFF_FFF0);
    send_item(OP_FREE, 32'hFFFF_FFF1);
    send_item(OP_FREE, 32'h0000_0000);
    drain_results();

    // Directed: largest unit size, count above capacity, units wrapping past 2^32
    write_reg(CFG_POOL_BASE, 32'hFFFF_F000);
    write_reg(CFG_UNIT_BYTES, 32'd8191);
    write_reg(CFG_UNITS, 32'd2047);
    send_item(OP_ALLOC, 32'h0);
    send_item(OP_ALLOC, 32'h0);
    send_item(OP_FREE, 32'h0000_0FFF);
    send_item(OP_FREE, 32'hFFFF_F001);
    send_item(OP_ALLOC, 32'h0);
    drain_results();

    // Directed: shrink the count below units still in use
    write_reg(CFG_UNITS, 32'd1);
    send_item(OP_FREE, 32'h0000_0FFF);
    send_item(OP_ALLOC, 32'h0);
    send_item(OP_INIT, 32'h0);
    drain_results();
    write_reg(CFG_POOL_BASE, 32'h0);
    write_reg(CFG_UNIT_BYTES, 32'd4096);
    write_reg(CFG_UNITS, 32'd1024);

    // Random phases; the last few keep a full-size pool and fill it deep
    burst_left = 0;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      deep = (phase >= RANDOM_PHASES - DEEP_PHASES);
      drain_results();
      stall_mode   <= 2'($urandom_range(0, 2));
      sender_idles = ($urandom_range(0, 3) != 0);
      pause_at     = (phase == 3 || $urandom_range(0, 2) == 0) ?
                     $urandom_range(10, PHASE_ITEMS - 10) : -1;

      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 3))
          0:       value = 32'h0;
          1:       value = $urandom();
          2:       value = 32'hFFFF_FFFF - $urandom_range(0, 4095);
          default: value = 32'h1000 * $urandom_range(0, 15);
        endcase
        write_reg(CFG_POOL_BASE, value);
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 5))
          0:       value = 32'd0;
          1:       value = 32'd1;
          2:       value = 32'd4096;
          3:       value = 32'd8191;
          4:       value = $urandom_range(1, 4096);
          default: value = $urandom_range(1, 128);
        endcase
        write_reg(CFG_UNIT_BYTES, value | ($urandom() << UNIT_W));
      end
      if (phase == RANDOM_PHASES - DEEP_PHASES) begin
        write_reg(CFG_UNITS, 32'd1024);
        send_item(OP_INIT, $urandom());
      end else if (!deep && $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 5))
          0:       value = 32'd0;
          1:       value = 32'd1;
          2:       value = 32'd2047;
          3:       value = 32'd1024;
          default: value = $urandom_range(1, 64);
        endcase
        write_reg(CFG_UNITS, value | ($urandom() << RANGE_W));
      end

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // bursts separated by random gaps
        if (sender_idles && burst_left == 0) begin
          in_tvalid <= 1'b0;
          repeat ($urandom_range(1, 15)) @(posedge clk);
          burst_left = $urandom_range(1, 12);
        end
        // hold off until everything in flight has come back
        if (k == pause_at) drain_results();
        random_item(deep ? 80 : 48, !deep);
        if (burst_left > 0) burst_left--;
      end
    end

    drain_results();
    repeat (64) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
